@@ rtl/core/firq15_pkg.sv @@
// ----------------------------------------------------------------------------
// firq15_pkg
// Shared widths, command codes and control bundles of the Q1.15 FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package firq15_pkg;

   localparam int TAPS   = 32;
   localparam int DATA_W = 16;
   localparam int IDX_W  = 5;
   localparam int FRAC_W = 15;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);
   localparam int SH_W   = ACC_W - FRAC_W;
   localparam int CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef logic signed [DATA_W-1:0] q15_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic mult;
   } mac_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/firq15_cell.sv @@
// ----------------------------------------------------------------------------
// firq15_cell
// One tap of the ring: holds a delayed sample and its weight, and hands both
// to the next tap whenever the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module firq15_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  firq15_pkg::cell_ctrl_type  ctrl,
   input  firq15_pkg::q15_type        shift_sample,
   input  firq15_pkg::q15_type        rot_sample,
   input  firq15_pkg::q15_type        rot_weight,
   input  wire                        load_hit,
   input  firq15_pkg::q15_type        load_value,
   output firq15_pkg::q15_type        sample,
   output firq15_pkg::q15_type        weight
);
   import firq15_pkg::*;

   q15_type sample_ff, sample_in;
   q15_type weight_ff, weight_in;

   always_comb begin
      priority if (ctrl.shift) begin
         sample_in = shift_sample;
      end else if (ctrl.rotate) begin
         sample_in = rot_sample;
      end else begin
         sample_in = sample_ff;
      end

      priority if (ctrl.rotate) begin
         weight_in = rot_weight;
      end else if (load_hit) begin
         weight_in = load_value;
      end else begin
         weight_in = weight_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         weight_ff <= '0;
      end else begin
         sample_ff <= sample_in;
         weight_ff <= weight_in;
      end
   end

   assign sample = sample_ff;
   assign weight = weight_ff;

endmodule

`default_nettype wire

@@ rtl/core/firq15_mac.sv @@
// ----------------------------------------------------------------------------
// firq15_mac
// Multiply-accumulate at the tail of the ring, with floor shift by 15 and
// saturation of the finished sum to Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module firq15_mac (
   input  wire                       clock,
   input  wire                       reset,
   input  firq15_pkg::mac_ctrl_type  ctrl,
   input  firq15_pkg::q15_type       tap_sample,
   input  firq15_pkg::q15_type       tap_weight,
   output firq15_pkg::q15_type       filtered
);
   import firq15_pkg::*;

   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
   localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(32768);

   prod_type prod_ff, prod_in;
   logic     prod_vld_ff, prod_vld_in;
   acc_type  acc_ff, acc_in;
   logic signed [SH_W-1:0] shifted;

   assign prod_in     = tap_sample * tap_weight;
   assign prod_vld_in = ctrl.mult;

   always_comb begin
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Arithmetic shift rounds towards minus infinity, as required.
   assign shifted = SH_W'(acc_ff >>> FRAC_W);

   always_comb begin
      priority if (shifted > SAT_HI) begin
         filtered = q15_type'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         filtered = q15_type'(SAT_LO);
      end else begin
         filtered = q15_type'(shifted);
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/fir_filter_q15.sv @@
// A sample word is filtered over the RUN, SUM and DONE states before its result reaches rsp_;
// no new request is taken until then. Load words are taken one per cycle while idle.
// The single multiply-accumulate at the ring tail sees one tap per cycle.
// Reset (synchronous): delay line and weights clear to zero, no result pending.
// Requests stall while a sample is being filtered.
// ----------------------------------------------------------------------------
// fir_filter_q15
// Direct-form FIR filter on Q1.15 samples built as a rotating ring of taps.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_q15 (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_command,
   input  wire [firq15_pkg::IDX_W-1:0]  req_tap_index,
   input  firq15_pkg::q15_type          req_value,
   input  wire                          req_block_end,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output firq15_pkg::q15_type          rsp_filtered,
   output logic                         rsp_block_last
);
   import firq15_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   q15_type          rsp_filtered_ff;
   logic             rsp_last_ff;

   logic          req_acc, sample_acc, load_acc, out_load;
   cell_ctrl_type cell_ctrl;
   mac_ctrl_type  mac_ctrl;
   logic [TAPS-1:0] load_hit;
   q15_type       sample_q [TAPS];
   q15_type       weight_q [TAPS];
   q15_type       mac_filtered;

   assign req_acc    = req_valid & ~req_stall;
   assign sample_acc = req_acc & (req_command == CMD_SAMPLE);
   assign load_acc   = req_acc & (req_command == CMD_LOAD);
   assign out_load   = (state_ff == ST_DONE) & (~rsp_valid_ff | ~rsp_stall);

   assign cell_ctrl.shift  = sample_acc;
   assign cell_ctrl.rotate = (state_ff == ST_RUN);
   assign mac_ctrl.clear   = sample_acc;
   assign mac_ctrl.mult    = (state_ff == ST_RUN);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (sample_acc) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TAPS - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign last_in      = sample_acc ? req_block_end : last_ff;
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (out_load) begin
         rsp_filtered_ff <= mac_filtered;
         rsp_last_ff     <= last_ff;
      end
   end

   // Each tap takes from its predecessor; the first tap closes the ring from
   // the last one, so TAPS rotations bring every pair back to its place.
   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      localparam int PREV = (k == 0) ? TAPS - 1 : k - 1;
      q15_type shift_src;

      assign load_hit[k] = load_acc & (int'(req_tap_index) == k);

      if (k == 0) begin : g_head
         assign shift_src = req_value;
      end else begin : g_body
         assign shift_src = sample_q[PREV];
      end

      firq15_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .shift_sample (shift_src),
         .rot_sample   (sample_q[PREV]),
         .rot_weight   (weight_q[PREV]),
         .load_hit     (load_hit[k]),
         .load_value   (req_value),
         .sample       (sample_q[k]),
         .weight       (weight_q[k])
      );
   end

   firq15_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .tap_sample (sample_q[TAPS-1]),
      .tap_weight (weight_q[TAPS-1]),
      .filtered   (mac_filtered)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered   = rsp_filtered_ff;
   assign rsp_block_last = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/core/firq15_chk.sv @@
// ----------------------------------------------------------------------------
// firq15_chk
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module firq15_chk (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_stall,
   input wire                  req_command,
   input wire                  rsp_valid,
   input wire                  rsp_stall,
   input firq15_pkg::q15_type  rsp_filtered,
   input wire                  rsp_block_last
);
   import firq15_pkg::*;

   // A sample word occupies the ring, so the next word must wait.
   a_sample_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_SAMPLE) |=> req_stall)
      else $error("request not stalled after a sample word");

   // A load word never produces a result word.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_LOAD && !rsp_valid) |=> !rsp_valid)
      else $error("result word appeared after a load word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_filtered) && $stable(rsp_block_last)))
      else $error("stalled result word changed");

endmodule

bind fir_filter_q15 firq15_chk u_firq15_chk (.*);

`default_nettype wire
